>>> src/tls_handshake_record_deframer_macros.svh
// Assertion macros for the handshake record deframer checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef TLS_HANDSHAKE_RECORD_DEFRAMER_MACROS_SVH
`define TLS_HANDSHAKE_RECORD_DEFRAMER_MACROS_SVH

// Same-cycle implication.
`define TLSHRD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TLSHRD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/tlshrd_pkg.sv
// Types and constants for the handshake record deframer.
// No dependencies.
`timescale 1ns / 1ps

package tlshrd_pkg;

  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] REG_CONTENT_TYPE = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_VERSION      = 1'd1;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_ARM  = 1'b1;

  localparam logic [7:0]  CONTENT_TYPE_RST = 8'd22;
  localparam logic [15:0] VERSION_RST      = 16'd771;
  localparam logic [15:0] HDR_BYTES        = 16'd4;

  localparam logic [7:0] HS_SERVER_HELLO = 8'd2;
  localparam logic [7:0] HS_CERT_REQUEST = 8'd13;
  localparam logic [7:0] HS_HELLO_DONE   = 8'd14;

  typedef enum logic [1:0] {
    KIND_IDLE    = 2'd0,
    KIND_DISCARD = 2'd1,
    KIND_HEADER  = 2'd2,
    KIND_PAYLOAD = 2'd3
  } byte_kind_e;

  typedef enum logic [10:0] {
    M_IDLE    = 11'b000_0000_0001,
    M_HUNT    = 11'b000_0000_0010,
    M_VER_HI  = 11'b000_0000_0100,
    M_VER_LO  = 11'b000_0000_1000,
    M_REC_HI  = 11'b000_0001_0000,
    M_REC_LO  = 11'b000_0010_0000,
    M_TYPE    = 11'b000_0100_0000,
    M_LEN0    = 11'b000_1000_0000,
    M_LEN1    = 11'b001_0000_0000,
    M_LEN2    = 11'b010_0000_0000,
    M_PAYLOAD = 11'b100_0000_0000
  } parse_mode_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    byte_kind_e byte_kind;
    logic [7:0] byte_out;
    logic [7:0] message_type;
    logic       message_end;
    logic       record_end;
    logic       send_certificates;
  } out_item_t;

endpackage

>>> src/tls_handshake_record_deframer.sv
// Handshake record deframer: byte-wise TLS record and handshake message parser.
// Depends on tlshrd_pkg.
//
//  channel | signals                                  | direction
//  in      | in_valid_i, in_ready_o, in_data_i        | sink
//  out     | out_valid_o, out_ready_i, out_data_o     | source
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i,   | sink
//          | cfg_data_i                               |
//
// One beat per cycle while the output register can take it; each accepted byte yields one result
// beat in the next cycle, held in the output register that captures the combinational parser result.
// in_ready_o is high while the output register is empty or being drained.
// Config writes are always taken. Reset is async, active low: parser idle, counters zero.
`timescale 1ns / 1ps

module tls_handshake_record_deframer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  tlshrd_pkg::in_item_t           in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tlshrd_pkg::out_item_t          out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tlshrd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [tlshrd_pkg::CfgDataW-1:0] cfg_data_i
);
  import tlshrd_pkg::*;

  logic [7:0]  ctype_q;
  logic [15:0] version_q;

  parse_mode_e mode_q, mode_d;
  logic [15:0] rrem_q, rrem_d;
  logic [23:0] mlen_q, mlen_d;
  logic [23:0] pcnt_q, pcnt_d;
  logic [7:0]  ctyp_q, ctyp_d;
  logic        creq_q, creq_d;

  logic        out_valid_q;
  out_item_t   out_q, res;

  logic        in_acc;
  logic        fin;
  logic [23:0] fin_len;
  logic [15:0] rrem_sub;
  logic [7:0]  b;
  logic [23:0] pcnt_inc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign b           = in_data_i.data_byte;
  assign pcnt_inc    = pcnt_q + 24'd1;
  assign rrem_sub    = (rrem_q >= HDR_BYTES) ? rrem_q - HDR_BYTES : 16'd0;

  always_comb begin
    mode_d  = mode_q;
    rrem_d  = rrem_q;
    mlen_d  = mlen_q;
    pcnt_d  = pcnt_q;
    ctyp_d  = ctyp_q;
    creq_d  = creq_q;
    fin     = 1'b0;
    fin_len = mlen_q;
    res     = '0;
    res.byte_out = b;
    res.byte_kind = KIND_IDLE;

    if (in_data_i.operation == OP_ARM) begin
      mode_d = M_HUNT;
    end else begin
      unique case (mode_q)
        M_HUNT: begin
          if (b == ctype_q) begin
            rrem_d = '0;
            mlen_d = '0;
            pcnt_d = '0;
            ctyp_d = '0;
            mode_d = M_VER_HI;
            res.byte_kind = KIND_HEADER;
          end else begin
            res.byte_kind = KIND_DISCARD;
          end
        end
        M_VER_HI: begin
          if (b == version_q[15:8]) begin
            mode_d = M_VER_LO;
            res.byte_kind = KIND_HEADER;
          end else begin
            res.byte_kind = KIND_DISCARD;
          end
        end
        M_VER_LO: begin
          if (b == version_q[7:0]) begin
            mode_d = M_REC_HI;
            res.byte_kind = KIND_HEADER;
          end else begin
            res.byte_kind = KIND_DISCARD;
          end
        end
        M_REC_HI: begin
          rrem_d = {b, 8'd0};
          mode_d = M_REC_LO;
          res.byte_kind = KIND_HEADER;
        end
        M_REC_LO: begin
          rrem_d = {rrem_q[15:8], b};
          mode_d = M_TYPE;
          res.byte_kind = KIND_HEADER;
        end
        M_TYPE: begin
          ctyp_d = b;
          mode_d = M_LEN0;
          res.byte_kind = KIND_HEADER;
        end
        M_LEN0: begin
          mlen_d = {b, 16'd0};
          mode_d = M_LEN1;
          res.byte_kind = KIND_HEADER;
        end
        M_LEN1: begin
          mlen_d = {mlen_q[23:16], b, 8'd0};
          mode_d = M_LEN2;
          res.byte_kind = KIND_HEADER;
        end
        M_LEN2: begin
          mlen_d  = {mlen_q[23:8], b};
          fin_len = {mlen_q[23:8], b};
          pcnt_d  = '0;
          res.byte_kind = KIND_HEADER;
          if ({mlen_q[23:8], b} == 24'd0) begin
            fin = 1'b1;
          end else begin
            mode_d = M_PAYLOAD;
          end
        end
        M_PAYLOAD: begin
          res.byte_kind = KIND_PAYLOAD;
          pcnt_d = pcnt_inc;
          if (pcnt_inc >= mlen_q) begin
            fin = 1'b1;
          end
        end
        default: begin
          mode_d = M_IDLE;
        end
      endcase
    end

    if (fin) begin
      res.message_end = 1'b1;
      pcnt_d = '0;
      if (ctyp_q == HS_SERVER_HELLO) begin
        creq_d = 1'b0;
      end else if (ctyp_q == HS_CERT_REQUEST) begin
        creq_d = 1'b1;
      end else if (ctyp_q == HS_HELLO_DONE) begin
        res.send_certificates = creq_q;
      end
      if (fin_len >= {8'd0, rrem_sub}) begin
        rrem_d = '0;
        mode_d = M_HUNT;
        res.record_end = 1'b1;
      end else begin
        rrem_d = rrem_sub - fin_len[15:0];
        mode_d = M_TYPE;
      end
    end

    if (res.byte_kind == KIND_HEADER || res.byte_kind == KIND_PAYLOAD) begin
      res.message_type = ctyp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctype_q   <= CONTENT_TYPE_RST;
      version_q <= VERSION_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CONTENT_TYPE: ctype_q   <= cfg_data_i[7:0];
        REG_VERSION:      version_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      rrem_q <= '0;
      mlen_q <= '0;
      pcnt_q <= '0;
      ctyp_q <= '0;
      creq_q <= 1'b0;
    end else if (in_acc) begin
      mode_q <= mode_d;
      rrem_q <= rrem_d;
      mlen_q <= mlen_d;
      pcnt_q <= pcnt_d;
      ctyp_q <= ctyp_d;
      creq_q <= creq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= res;
    end
  end

endmodule

>>> src/tlshrd_checker.sv
// Port-level checker for the handshake record deframer, bound to the top level.
// Depends on tlshrd_pkg and tls_handshake_record_deframer_macros.svh.
`timescale 1ns / 1ps
`include "tls_handshake_record_deframer_macros.svh"

module tlshrd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input tlshrd_pkg::in_item_t            in_data_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input tlshrd_pkg::out_item_t           out_data_o
);
  import tlshrd_pkg::*;

  logic arm_acc;
  logic no_hdr;

  assign arm_acc = in_valid_i && in_ready_o && (in_data_i.operation == OP_ARM);
  assign no_hdr  = (out_data_o.byte_kind == KIND_IDLE) ||
                   (out_data_o.byte_kind == KIND_DISCARD);

  `TLSHRD_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
                     out_valid_o && $stable(out_data_o), "stalled result beat changed")
  `TLSHRD_ASSERT_NXT(a_arm_idle, arm_acc,
                     out_valid_o && out_data_o.byte_kind == KIND_IDLE &&
                     !out_data_o.message_end, "arm beat did not give an idle result")
  `TLSHRD_ASSERT_IMP(a_rec_msg, out_valid_o && out_data_o.record_end,
                     out_data_o.message_end, "record end without message end")
  `TLSHRD_ASSERT_IMP(a_send_done, out_valid_o && out_data_o.send_certificates,
                     out_data_o.message_end && out_data_o.message_type == HS_HELLO_DONE,
                     "send certificates outside hello done end")
  `TLSHRD_ASSERT_IMP(a_no_hdr, out_valid_o && no_hdr,
                     out_data_o.message_type == 8'd0 && !out_data_o.message_end,
                     "non-header beat carries message info")

endmodule

bind tls_handshake_record_deframer tlshrd_checker u_tlshrd_checker (.*);
